/* rtl/gbt_pkg.sv */
package gbt_pkg;

    // Default sizes of the graph and of the traversal work list.
    localparam int GBT_MAX_VERTICES = 16;
    localparam int GBT_WORK_DEPTH   = 256;

    // A traversal stops after this many visited vertices.
    localparam int RESULT_LIMIT = 16;

    // Field widths fixed by the interface.
    localparam int FUNC_W = 2;
    localparam int VERT_W = 4;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Item functions.
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BFS   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DFS   = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIST_FULL  = 2'd2;

    // Result offered by the sequencer to the output register.
    typedef struct packed {
        logic              valid;
        logic [VERT_W-1:0] vertex;
        logic [STAT_W-1:0] status;
        logic              last;
    } gbt_emit_t;

endpackage

/* rtl/gbt_ram.sv */
module gbt_ram
    import gbt_pkg::*;
#(
    parameter int DEPTH = GBT_WORK_DEPTH,
    parameter int WIDTH = VERT_W,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; the read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/gbt_seq.sv */
module gbt_seq
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES = GBT_MAX_VERTICES,
    parameter int WORK_DEPTH   = GBT_WORK_DEPTH,
    localparam int NW          = $clog2(MAX_VERTICES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [VERT_W-1:0] vertex,
    input  logic [VERT_W-1:0] neighbour,
    input  logic [NW-1:0]     n,
    output gbt_emit_t         emit,
    input  logic              emit_ok
);

    localparam int VIW   = $clog2(MAX_VERTICES);
    localparam int CW    = VIW;
    localparam int SDEP  = MAX_VERTICES * MAX_VERTICES;
    localparam int SAW   = $clog2(SDEP);
    localparam int WAW   = $clog2(WORK_DEPTH);
    localparam int KW    = $clog2(RESULT_LIMIT + 1);
    localparam int CPW   = (NW > VERT_W) ? NW : VERT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_POPW  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_SCANW = 4'd6;
    localparam logic [3:0] S_FLUSH = 4'd7;
    localparam logic [3:0] S_ONE   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [VERT_W-1:0] v_reg, v_next;
    logic [VERT_W-1:0] nb_reg, nb_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [WAW:0]      head_reg, head_next;
    logic [WAW:0]      tail_reg, tail_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [VIW-1:0]    x_reg, x_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [VIW-1:0]    pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CW-1:0]     count_reg [MAX_VERTICES];
    logic [CW-1:0]     count_next [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] mark_reg, mark_next;

    logic              store_we, store_re;
    logic [SAW-1:0]    store_waddr, store_raddr;
    logic [VIW-1:0]    store_wdata, store_rdata;
    logic              work_we, work_re;
    logic [WAW-1:0]    work_waddr, work_raddr;
    logic [VIW-1:0]    work_wdata, work_rdata;

    logic              is_bfs, v_bad, nb_bad, list_full, x_ok, w_ok;
    logic [VIW-1:0]    v_idx, w;
    logic [CW-1:0]     count_v;
    logic [WAW:0]      tail_dec;

    gbt_ram #(.DEPTH(SDEP), .WIDTH(VIW)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    gbt_ram #(.DEPTH(WORK_DEPTH), .WIDTH(VIW)) u_work (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (work_re),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign is_bfs    = (func_reg == FN_BFS);
    assign v_idx     = VIW'(v_reg);
    assign count_v   = count_reg[v_idx];
    assign v_bad     = CPW'(v_reg) >= CPW'(n);
    assign nb_bad    = CPW'(nb_reg) >= CPW'(n);
    assign list_full = CPW'(count_v) >= (CPW'(n) - CPW'(1));
    assign tail_dec  = tail_reg - (WAW + 1)'(1);
    assign x_ok      = (CPW'(work_rdata) < CPW'(n)) && (is_bfs || !mark_reg[work_rdata]);
    assign w         = store_rdata;
    assign w_ok      = (CPW'(w) < CPW'(n)) && !mark_reg[w]
                       && (tail_reg != (WAW + 1)'(WORK_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        v_next          = v_reg;
        nb_next         = nb_reg;
        st_next         = st_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        k_next          = k_reg;
        x_next          = x_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        mark_next       = mark_reg;

        store_we    = 1'b0;
        store_waddr = SAW'(int'(v_idx) * MAX_VERTICES + int'(count_v));
        store_wdata = VIW'(nb_reg);
        store_re    = 1'b0;
        store_raddr = SAW'(int'(x_reg) * MAX_VERTICES + int'(i_reg));
        work_we     = 1'b0;
        work_waddr  = tail_reg[WAW-1:0];
        work_wdata  = w;
        work_re     = 1'b0;
        work_raddr  = is_bfs ? head_reg[WAW-1:0] : tail_dec[WAW-1:0];
        emit        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    v_next    = vertex;
                    nb_next   = neighbour;
                    unique case (func)
                        FN_CLEAR:
                        begin
                            count_next = '{default: '0};
                            st_next    = ST_OK;
                            state_next = S_ONE;
                        end
                        FN_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        FN_BFS, FN_DFS:
                        begin
                            state_next = S_START;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (v_bad || nb_bad)
                begin
                    st_next = ST_BAD_VERTEX;
                end
                else if (list_full)
                begin
                    st_next = ST_LIST_FULL;
                end
                else
                begin
                    store_we          = 1'b1;
                    count_next[v_idx] = count_v + CW'(1);
                    st_next           = ST_OK;
                end
                state_next = S_ONE;
            end
            S_START:
            begin
                if (v_bad)
                begin
                    st_next    = ST_BAD_VERTEX;
                    state_next = S_ONE;
                end
                else
                begin
                    mark_next = '0;
                    if (is_bfs)
                    begin
                        mark_next[v_idx] = 1'b1;
                    end
                    work_we         = 1'b1;
                    work_waddr      = '0;
                    work_wdata      = v_idx;
                    head_next       = '0;
                    tail_next       = (WAW + 1)'(1);
                    k_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_POP;
                end
            end
            S_POP:
            begin
                if ((is_bfs ? (head_reg == tail_reg) : (tail_reg == '0))
                    || (k_reg == KW'(RESULT_LIMIT)))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    work_re = 1'b1;
                    if (is_bfs)
                    begin
                        head_next = head_reg + (WAW + 1)'(1);
                    end
                    else
                    begin
                        tail_next = tail_dec;
                    end
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                if (!x_ok)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    // The previous vertex is not the final one: hand it on first.
                    emit.valid  = pend_valid_reg;
                    emit.vertex = VERT_W'(pend_reg);
                    emit.status = ST_OK;
                    emit.last   = 1'b0;
                    if (!pend_valid_reg || emit_ok)
                    begin
                        pend_next       = work_rdata;
                        pend_valid_next = 1'b1;
                        k_next          = k_reg + KW'(1);
                        if (!is_bfs)
                        begin
                            mark_next[work_rdata] = 1'b1;
                        end
                        x_next     = work_rdata;
                        cnt_next   = count_reg[work_rdata];
                        i_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    store_re   = 1'b1;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (w_ok)
                begin
                    work_we   = 1'b1;
                    tail_next = tail_reg + (WAW + 1)'(1);
                    if (is_bfs)
                    begin
                        mark_next[w] = 1'b1;
                    end
                end
                state_next = S_SCAN;
            end
            S_FLUSH:
            begin
                emit.valid  = pend_valid_reg;
                emit.vertex = VERT_W'(pend_reg);
                emit.status = ST_OK;
                emit.last   = 1'b1;
                if (!pend_valid_reg || emit_ok)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_ONE:
            begin
                emit.valid  = 1'b1;
                emit.vertex = '0;
                emit.status = st_reg;
                emit.last   = 1'b1;
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            k_reg          <= '0;
            count_reg      <= '{default: '0};
            mark_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            k_reg          <= k_next;
            count_reg      <= count_next;
            mark_reg       <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        v_reg    <= v_next;
        nb_reg   <= nb_next;
        st_reg   <= st_next;
        x_reg    <= x_next;
        cnt_reg  <= cnt_next;
        i_reg    <= i_next;
        pend_reg <= pend_next;
    end

endmodule

/* rtl/graph_bfs_dfs_traversal.sv */
// A clear passes through S_ONE and an add through S_ADD and then S_ONE; each gives its one
// result through the output register, and the next item waits, as in_ready is high only when idle.
// A traversal pops work-list entries, visits vertices and scans neighbour entries, one memory
// access a cycle while the output is not held off.
// Reset (asynchronous, active low) sets vertex_count to 16, empties all lists and returns the block to idle.
module graph_bfs_dfs_traversal
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES = GBT_MAX_VERTICES,
    parameter int WORK_DEPTH   = GBT_WORK_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [VERT_W-1:0] vertex,
    input  logic [VERT_W-1:0] neighbour,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VERT_W-1:0] visited_vertex,
    output logic [STAT_W-1:0] status,
    output logic              last
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [CFG_W-1:0]  vc_reg;
    logic [NW-1:0]     n;
    gbt_emit_t         emit;
    logic              out_free;
    logic              out_valid_reg;
    logic [VERT_W-1:0] vis_reg;
    logic [STAT_W-1:0] status_reg;
    logic              last_reg;

    // The user must write the vertex count register only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            vc_reg <= cfg_wr_data;
        end
    end

    // Live vertex count: a count of zero behaves as one, and anything above the
    // capacity of the lists behaves as the capacity.
    always_comb
    begin
        if (vc_reg == '0)
        begin
            n = NW'(1);
        end
        else if (int'(vc_reg) > MAX_VERTICES)
        begin
            n = NW'(MAX_VERTICES);
        end
        else
        begin
            n = NW'(vc_reg);
        end
    end

    // The sequencer owns the lists, the visited marks and both memories, and
    // walks the graph one memory access at a time.
    gbt_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .WORK_DEPTH   (WORK_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .vertex    (vertex),
        .neighbour (neighbour),
        .n         (n),
        .emit      (emit),
        .emit_ok   (out_free)
    );

    // Output register: it takes a new result whenever it is empty or its
    // current result is being transferred in the same cycle, so the sequencer
    // stalls only when the consumer holds off.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid && out_free)
        begin
            vis_reg    <= emit.vertex;
            status_reg <= emit.status;
            last_reg   <= emit.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visited_vertex = vis_reg;
    assign status         = status_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    // The sequencer never offers a result while it is waiting for an item.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !emit.valid)
        else $error("result offered while the sequencer is idle");

    // An accepted item keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted straight after a transfer");

    // Error results stand alone and carry no vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (last && (visited_vertex == '0)))
        else $error("error result is not a lone final result");

    // The live vertex count always lies within the capacity of the lists.
    assert property (@(posedge clk) disable iff (!rst_n)
        (n != '0) && (int'(n) <= MAX_VERTICES))
        else $error("live vertex count out of range");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import gbt_pkg::*;

    // Clock period is 12 ns; the watchdog counts cycles without any transfer.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 40;
    localparam int RANDOM_ITEMS   = 280;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 60;

    // One result of the block: the visited vertex, its status and the last flag.
    typedef struct packed {
        logic [VERT_W-1:0] vtx;
        logic [STAT_W-1:0] st;
        logic              lst;
    } visit_t;

    // One row of the directed table. A row either writes vertex_count or sends
    // an item; where typed is set, the single expected result is given in the
    // row itself rather than worked out by the graph model below.
    typedef struct packed {
        bit                is_cfg;
        logic [CFG_W-1:0]  cfg_val;
        logic [FUNC_W-1:0] f;
        logic [VERT_W-1:0] v;
        logic [VERT_W-1:0] nb;
        bit                typed;
        visit_t            res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic [FUNC_W-1:0] func;
    logic [VERT_W-1:0] vertex;
    logic [VERT_W-1:0] neighbour;
    logic              out_valid;
    logic              out_ready;
    logic [VERT_W-1:0] visited_vertex;
    logic [STAT_W-1:0] status;
    logic              last;

    graph_bfs_dfs_traversal u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .vertex         (vertex),
        .neighbour      (neighbour),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visited_vertex (visited_vertex),
        .status         (status),
        .last           (last)
    );

    // Results still owed by the block, oldest first, and the results of the
    // item most recently applied to the graph model.
    visit_t expected_visits[$];
    visit_t item_visits[$];

    // Private copy of the graph: register, neighbour lists, marks and work list.
    logic [CFG_W-1:0]  vcount_reg;
    logic [VERT_W-1:0] adj_list [GBT_MAX_VERTICES][GBT_MAX_VERTICES];
    int                adj_len  [GBT_MAX_VERTICES];
    bit                mark     [GBT_MAX_VERTICES];
    logic [VERT_W-1:0] work     [GBT_WORK_DEPTH];

    stim_row_t directed_rows[$];

    int  errors;
    int  reports;
    int  items_sent;
    int  results_seen;
    int  cfg_writes;
    int  longest_walk;
    int  burst_left;
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The register value as the block uses it: zero acts as one, and anything
    // above the graph size acts as the graph size.
    function automatic int live_vertices();
        if (vcount_reg == 0)
            return 1;
        if (vcount_reg > GBT_MAX_VERTICES)
            return GBT_MAX_VERTICES;
        return int'(vcount_reg);
    endfunction

    function automatic void note_visit(input int x, input logic [STAT_W-1:0] st);
        visit_t t;
        t.vtx = x[VERT_W-1:0];
        t.st  = st;
        t.lst = 1'b0;
        item_visits.push_back(t);
    endfunction

    // Applies one item to the model graph and leaves its results, in order,
    // in item_visits. Breadth-first marks a vertex when it is queued;
    // depth-first marks it when it is popped, so the stack can hold repeats.
    task automatic apply_to_graph(input logic [FUNC_W-1:0] f,
                                  input logic [VERT_W-1:0] v,
                                  input logic [VERT_W-1:0] nb);
        int     n;
        int     head;
        int     tail;
        int     x;
        int     w;
        visit_t t;
        item_visits.delete();
        n = live_vertices();
        if (f == FN_CLEAR)
        begin
            for (int i = 0; i < GBT_MAX_VERTICES; i++)
                adj_len[i] = 0;
            note_visit(0, ST_OK);
        end
        else if (f == FN_ADD)
        begin
            if (int'(v) >= n || int'(nb) >= n)
                note_visit(0, ST_BAD_VERTEX);
            else if (adj_len[v] >= n - 1)
                note_visit(0, ST_LIST_FULL);
            else
            begin
                adj_list[v][adj_len[v]] = nb;
                adj_len[v]++;
                note_visit(0, ST_OK);
            end
        end
        else if (int'(v) >= n)
            note_visit(0, ST_BAD_VERTEX);
        else
        begin
            for (int i = 0; i < GBT_MAX_VERTICES; i++)
                mark[i] = 1'b0;
            head = 0;
            tail = 0;
            work[tail] = v;
            tail++;
            if (f == FN_BFS)
            begin
                mark[v] = 1'b1;
                while (head != tail && item_visits.size() < RESULT_LIMIT)
                begin
                    x = int'(work[head]);
                    head++;
                    note_visit(x, ST_OK);
                    for (int i = 0; i < adj_len[x]; i++)
                    begin
                        w = int'(adj_list[x][i]);
                        if (w < n && !mark[w] && tail < GBT_WORK_DEPTH)
                        begin
                            work[tail] = w[VERT_W-1:0];
                            tail++;
                            mark[w] = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                while (tail > 0 && item_visits.size() < RESULT_LIMIT)
                begin
                    tail--;
                    x = int'(work[tail]);
                    if (x < n && !mark[x])
                    begin
                        note_visit(x, ST_OK);
                        mark[x] = 1'b1;
                        for (int i = 0; i < adj_len[x]; i++)
                        begin
                            w = int'(adj_list[x][i]);
                            if (w < n && !mark[w] && tail < GBT_WORK_DEPTH)
                            begin
                                work[tail] = w[VERT_W-1:0];
                                tail++;
                            end
                        end
                    end
                end
            end
        end
        t = item_visits.pop_back();
        t.lst = 1'b1;
        item_visits.push_back(t);
        if (item_visits.size() > longest_walk)
            longest_walk = item_visits.size();
    endtask

    // Offers one item and holds it until the transfer. The expected results
    // are queued at the transfer edge, well before the first can appear.
    // The sender works in bursts: valid is only lowered when a burst ends.
    task automatic send_item(input logic [FUNC_W-1:0] f,
                             input logic [VERT_W-1:0] v,
                             input logic [VERT_W-1:0] nb,
                             input bit typed,
                             input visit_t typed_res);
        int gap;
        in_valid  <= 1'b1;
        func      <= f;
        vertex    <= v;
        neighbour <= nb;
        do
            @(posedge clk);
        while (!in_ready);
        apply_to_graph(f, v, nb);
        if (typed)
            expected_visits.push_back(typed_res);
        else
            foreach (item_visits[i])
                expected_visits.push_back(item_visits[i]);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(12, 1);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10)
                                                     : $urandom_range(6, 0);
        end
    endtask

    // The register is only written with the block idle: the sender stops,
    // every owed result has to arrive, and the block has to take items again.
    task automatic set_vertex_count(input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_visits.size() != 0 || !in_ready);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        vcount_reg  = val;
        cfg_writes++;
    endtask

    function automatic stim_row_t row_op(input logic [FUNC_W-1:0] f,
                                         input logic [VERT_W-1:0] v,
                                         input logic [VERT_W-1:0] nb);
        stim_row_t r;
        r         = '0;
        r.f       = f;
        r.v       = v;
        r.nb      = nb;
        return r;
    endfunction

    function automatic stim_row_t row_chk(input logic [FUNC_W-1:0] f,
                                          input logic [VERT_W-1:0] v,
                                          input logic [VERT_W-1:0] nb,
                                          input logic [VERT_W-1:0] ev,
                                          input logic [STAT_W-1:0] es);
        stim_row_t r;
        r         = row_op(f, v, nb);
        r.typed   = 1'b1;
        r.res.vtx = ev;
        r.res.st  = es;
        r.res.lst = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input logic [CFG_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = val;
        return r;
    endfunction

    // Receiver: ready cycles through four patterns, and once,
    // after enough results have come, it holds off for a long stretch so the
    // block stalls with an item waiting at its input.
    initial
    begin
        int rx_cycle;
        int mode;
        out_ready = 1'b0;
        rx_cycle  = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                mode = (rx_cycle / 97) % 4;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(1, 0));
                    2:       out_ready <= (rx_cycle % 4 == 0);
                    default: out_ready <= ($urandom_range(7, 0) != 0);
                endcase
            end
        end
    end

    // Result checker: every result transfer is compared with the oldest
    // expectation, field by field.
    initial
    begin
        visit_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (expected_visits.size() == 0)
                begin
                    errors++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: result with nothing expected: vertex %0d status %0d last %0d",
                                 $time, visited_vertex, status, last);
                    reports++;
                end
                else
                begin
                    want = expected_visits.pop_front();
                    if (visited_vertex !== want.vtx)
                    begin
                        errors++;
                        if (reports < MAX_REPORTS)
                            $display("%0t: visited_vertex expected %0d, actual %0d",
                                     $time, want.vtx, visited_vertex);
                        reports++;
                    end
                    if (status !== want.st)
                    begin
                        errors++;
                        if (reports < MAX_REPORTS)
                            $display("%0t: status expected %0d, actual %0d",
                                     $time, want.st, status);
                        reports++;
                    end
                    if (last !== want.lst)
                    begin
                        errors++;
                        if (reports < MAX_REPORTS)
                            $display("%0t: last expected %0d, actual %0d",
                                     $time, want.lst, last);
                        reports++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for
    // too long, which also catches results that never arrive.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results still owed",
                         $time, quiet, expected_visits.size());
                $display("[graph_bfs_dfs_traversal] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int     n;
        int     goal;
        int     phase;
        int     count;
        int     pick;
        visit_t none;
        logic [CFG_W-1:0]  cfg_plan [12];
        logic [FUNC_W-1:0] rf;
        logic [VERT_W-1:0] rv;
        logic [VERT_W-1:0] rnb;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        func         = FN_CLEAR;
        vertex       = '0;
        neighbour    = '0;
        errors       = 0;
        reports      = 0;
        items_sent   = 0;
        results_seen = 0;
        cfg_writes   = 0;
        longest_walk = 0;
        burst_left   = 0;
        hold_done    = 1'b0;
        none         = '0;
        vcount_reg   = CFG_RESET;
        for (int i = 0; i < GBT_MAX_VERTICES; i++)
            adj_len[i] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. After reset every list is empty and the graph has
        // sixteen vertices; later rows shrink it to four, to zero (acting as
        // one) and raise it to thirty-one (acting as sixteen).
        directed_rows.push_back(row_chk(FN_CLEAR, 4'd0, 4'd0, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_BFS, 4'd0, 4'd0, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_DFS, 4'd15, 4'd0, 4'd15, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd0, 4'd15, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd15, 4'd0, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd0, 4'd1, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd0, 4'd2, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd1, 4'd3, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd2, 4'd3, 4'd0, ST_OK));
        directed_rows.push_back(row_op(FN_BFS, 4'd0, 4'd0));
        directed_rows.push_back(row_op(FN_DFS, 4'd0, 4'd0));
        directed_rows.push_back(row_cfg(5'd4));
        directed_rows.push_back(row_chk(FN_ADD, 4'd4, 4'd0, 4'd0, ST_BAD_VERTEX));
        directed_rows.push_back(row_chk(FN_ADD, 4'd0, 4'd4, 4'd0, ST_BAD_VERTEX));
        directed_rows.push_back(row_chk(FN_ADD, 4'd3, 4'd0, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd3, 4'd1, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd3, 4'd2, 4'd0, ST_OK));
        directed_rows.push_back(row_chk(FN_ADD, 4'd3, 4'd3, 4'd0, ST_LIST_FULL));
        // Vertex 0 still lists vertex 15, which now lies outside the graph.
        directed_rows.push_back(row_op(FN_BFS, 4'd0, 4'd0));
        directed_rows.push_back(row_op(FN_DFS, 4'd3, 4'd0));
        directed_rows.push_back(row_chk(FN_BFS, 4'd7, 4'd0, 4'd0, ST_BAD_VERTEX));
        directed_rows.push_back(row_chk(FN_DFS, 4'd15, 4'd15, 4'd0, ST_BAD_VERTEX));
        directed_rows.push_back(row_cfg(5'd0));
        directed_rows.push_back(row_chk(FN_ADD, 4'd0, 4'd0, 4'd0, ST_LIST_FULL));
        directed_rows.push_back(row_chk(FN_BFS, 4'd0, 4'd0, 4'd0, ST_OK));
        directed_rows.push_back(row_cfg(5'd31));
        directed_rows.push_back(row_chk(FN_ADD, 4'd15, 4'd15, 4'd0, ST_OK));
        directed_rows.push_back(row_op(FN_DFS, 4'd15, 4'd0));
        directed_rows.push_back(row_chk(FN_CLEAR, 4'd9, 4'd6, 4'd0, ST_OK));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_vertex_count(directed_rows[i].cfg_val);
            else
                send_item(directed_rows[i].f, directed_rows[i].v, directed_rows[i].nb,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        // Random part, in phases. Each phase sets the register with the block
        // idle, usually clears the lists, builds a graph mostly from legal
        // edges (every third phase starts from a ring, so walks reach every
        // vertex), then runs several traversals and a few arbitrary items.
        // Phases without a clear keep lists built at another size, which
        // leaves stale entries behind.
        cfg_plan = '{5'd16, 5'd7, 5'd1, 5'd31, 5'd0, 5'd12,
                     5'd16, 5'd3, 5'd20, 5'd9, 5'd2, 5'd16};
        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal)
        begin
            if (phase < 12)
                set_vertex_count(cfg_plan[phase]);
            else
                set_vertex_count(CFG_W'($urandom_range(31, 0)));
            n = live_vertices();

            if (phase % 3 == 0 || $urandom_range(2, 0) != 0)
                send_item(FN_CLEAR, VERT_W'($urandom_range(15, 0)),
                          VERT_W'($urandom_range(15, 0)), 1'b0, none);

            if (phase % 3 == 0)
                for (int i = 0; i < n; i++)
                    send_item(FN_ADD, i[VERT_W-1:0], VERT_W'((i + 1) % n), 1'b0, none);

            count = $urandom_range(2 * n + 4, n);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(9, 0) == 0)
                begin
                    rv  = VERT_W'($urandom_range(15, 0));
                    rnb = VERT_W'($urandom_range(15, 0));
                end
                else
                begin
                    rv  = VERT_W'($urandom_range(n - 1, 0));
                    rnb = VERT_W'($urandom_range(n - 1, 0));
                end
                send_item(FN_ADD, rv, rnb, 1'b0, none);
            end

            count = $urandom_range(7, 3);
            for (int i = 0; i < count; i++)
            begin
                rf = ($urandom_range(1, 0) == 0) ? FN_BFS : FN_DFS;
                if ($urandom_range(7, 0) == 0)
                    rv = VERT_W'($urandom_range(15, 0));
                else
                    rv = VERT_W'($urandom_range(n - 1, 0));
                send_item(rf, rv, VERT_W'($urandom_range(15, 0)), 1'b0, none);
            end

            count = $urandom_range(3, 0);
            for (int i = 0; i < count; i++)
            begin
                pick = $urandom_range(3, 0);
                rf   = pick[FUNC_W-1:0];
                send_item(rf, VERT_W'($urandom_range(15, 0)),
                          VERT_W'($urandom_range(15, 0)), 1'b0, none);
            end
            phase++;
        end

        // Drain: every owed result must arrive, then a quiet stretch shows
        // that nothing further comes out.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_visits.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d items, %0d results, %0d register writes, %0d phases.",
                 items_sent, results_seen, cfg_writes, phase);
        $display("Longest traversal gave %0d results; receiver held off for %0d cycles once.",
                 longest_walk, HOLD_CYCLES);
        if (errors == 0 && expected_visits.size() == 0)
            $display("[graph_bfs_dfs_traversal] OK");
        else
            $display("[graph_bfs_dfs_traversal] ERROR");
        $finish;
    end

endmodule
